>>> hdl/bfa_pkg.sv
// Shared constants for the bitmap frame allocator: codes, field widths, defaults.
`timescale 1ns / 1ps

package bfa_pkg;

	localparam int FRAMES_DEF      = 1024;
	localparam int FRAME_BYTES_DEF = 4096;

	// request kinds (s_tuser)
	localparam logic [2:0] KIND_INIT    = 3'd0;
	localparam logic [2:0] KIND_ALLOC   = 3'd1;
	localparam logic [2:0] KIND_FREE    = 3'd2;
	localparam logic [2:0] KIND_RELEASE = 3'd3;
	localparam logic [2:0] KIND_RESERVE = 3'd4;

	// result status (m_tuser)
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [1:0] STATUS_BADREQ  = 2'd2;

	// configuration register indexes
	localparam logic CFG_MAP_BASE = 1'b0;
	localparam logic CFG_TOTAL    = 1'b1;

	localparam logic [31:0] MAP_BASE_RST = 32'd0;
	localparam logic [10:0] TOTAL_RST    = 11'd1024;

	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int ADDR_W    = 32;
	localparam int FCOUNT_W  = 11;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 48;

endpackage

>>> hdl/bitmap_frame_allocator_core.sv
// Top level: first-fit bitmap frame allocator with word-serial scan and fill unit.
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit first)                                     Handshake
// s_*       in   tuser: kind[2:0]; tdata: address, frame_count, region_bytes tvalid/tready
// m_*       out  tuser: status[1:0]; tdata: block_address, used_frames      tvalid/tready
// cfg_*     in   cfg_index (0 map_base, 1 total_frames), cfg_data           cfg_valid/cfg_ready
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Alloc: one map word per cycle through the scan unit, then one word per cycle through the
// read-modify-write fill. Free/release/reserve: the fill unit only, over the words covered.
// Init rewrites all FRAMES/32 words.
// After reset the map is set to all-used by a pass over all FRAMES/32 words with s_tready low.
// The result sits in an output register; a new request is taken while it waits.

module bitmap_frame_allocator_core import bfa_pkg::*; #(
	parameter int FRAMES      = FRAMES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // address[31:0], frame_count[42:32], region_bytes[74:43]
	input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // block_address[31:0], used_frames[42:32]
	output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int MAP_WORDS = FRAMES / 32;
	localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int TW        = $clog2(FRAMES + 1);
	localparam int FBS       = $clog2(FRAME_BYTES);
	localparam int AW_A      = 33 - FBS;
	localparam int AW        = (AW_A > TW + 1) ? AW_A : TW + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FILL,
		ST_COUNT,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [31:0]          map_base_q;
	logic [FCOUNT_W-1:0]  total_q;
	logic [TW-1:0]        count_q;

	logic [KIND_W-1:0]    kind_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [FCOUNT_W-1:0]  cnt_q;
	logic [31:0]          rbytes_q;
	logic                 init_q;

	logic [WW-1:0]        rd_word_q;
	logic [WW-1:0]        ev_s1;
	logic                 pend_s1;
	logic [31:0]          rdata_s1;
	logic [AW-1:0]        run_q;
	logic [AW-1:0]        runst_q;

	logic [AW-1:0]        fill_first_q;
	logic [AW-1:0]        fill_n_q;
	logic                 fill_val_q;

	logic [STATUS_W-1:0]  status_q;
	logic [31:0]          block_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [31:0]          out_block_q;
	logic [FCOUNT_W-1:0]  out_used_q;

	logic [31:0]          used_map [MAP_WORDS];
	logic                 mem_we;
	logic [WW-1:0]        mem_wa;
	logic [31:0]          mem_wd;

	// count of trailing ones
	function automatic logic [5:0] trail_ones(input logic [31:0] x);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 31; i >= 0; i--) begin
			if (!x[i]) n = 6'(i);
		end
		return n;
	endfunction

	// count of leading ones
	function automatic logic [5:0] lead_ones(input logic [31:0] x);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (!x[i]) n = 6'(31 - i);
		end
		return n;
	endfunction

	// index of lowest set bit
	function automatic logic [4:0] low_set(input logic [31:0] x);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	// ---------------- shared combinational terms ----------------
	logic [TW-1:0] total_eff;
	logic [AW-1:0] total_a;
	logic [AW-1:0] count_c;
	logic [AW-1:0] cnt_a;
	logic [FCOUNT_W-1:0] used_c;

	always_comb begin
		if ({21'd0, total_q} > 32'(FRAMES)) total_eff = TW'(FRAMES);
		else                                 total_eff = TW'(total_q);
		total_a = AW'(total_eff);
		count_c = (AW'(count_q) > total_a) ? total_a : AW'(count_q);
		cnt_a   = AW'(cnt_q);
		used_c  = FCOUNT_W'(count_c);
	end

	// request decode
	logic [31:0]   free_diff;
	logic [AW-1:0] free_first;
	logic [AW-1:0] reg_first;
	logic [AW-1:0] reg_n;
	logic [AW-1:0] free_rest;
	logic [AW-1:0] reg_rest;
	logic [AW-1:0] reg_n_clip;

	always_comb begin
		free_diff  = addr_q - map_base_q;
		free_first = AW'(free_diff[31:FBS]);
		reg_first  = AW'(addr_q[31:FBS]);
		reg_n      = AW'(rbytes_q[31:FBS]);
		free_rest  = total_a - free_first;
		reg_rest   = total_a - reg_first;
		reg_n_clip = (reg_n > reg_rest) ? reg_rest : reg_n;
	end

	// ---------------- scan unit: one map word per cycle ----------------
	logic [AW-1:0]      sc_base;
	logic [AW-1:0]      sc_rem;
	logic [31:0]        sc_vm;
	logic [31:0]        sc_fm;
	logic [4:0][31:0]   sc_mk;
	logic [31:0]        sc_r;
	logic [5:0]         sc_off;
	logic [5:0]         sc_low;
	logic [5:0]         sc_high;
	logic               sc_hit_low;
	logic               sc_hit_in;
	logic               sc_found;
	logic [AW-1:0]      sc_start;
	logic               sc_last;
	logic [WW-1:0]      last_word;

	always_comb begin
		sc_base = AW'({ev_s1, 5'd0});
		sc_rem  = total_a - sc_base;
		sc_vm   = (sc_rem >= AW'(32)) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << sc_rem[4:0]);
		// frames at or past the total count as used
		sc_fm   = ~rdata_s1 & sc_vm;

		// sc_mk[b]: bit p set when 2^b frames from p are free
		sc_mk[0] = sc_fm;
		for (int b = 1; b < 5; b++) begin
			sc_mk[b] = sc_mk[b-1] & (sc_mk[b-1] >> (1 << (b - 1)));
		end
		sc_r   = 32'hFFFF_FFFF;
		sc_off = 6'd0;
		for (int b = 0; b < 5; b++) begin
			if (cnt_q[b]) begin
				sc_r   = sc_r & (sc_mk[b] >> sc_off);
				sc_off = sc_off + 6'(1 << b);
			end
		end

		sc_low     = trail_ones(sc_fm);
		sc_high    = lead_ones(sc_fm);
		sc_hit_low = (run_q + AW'(sc_low)) >= cnt_a;
		sc_hit_in  = (cnt_q < 11'd32) && (sc_r != 32'd0);
		sc_found   = sc_hit_low || sc_hit_in;
		if (sc_hit_low) sc_start = (run_q == '0) ? sc_base : runst_q;
		else            sc_start = sc_base + AW'(low_set(sc_r));

		last_word = WW'((total_a - AW'(1)) >> 5);
		sc_last   = (ev_s1 == last_word);
	end

	// ---------------- fill unit: read-modify-write one word per cycle ----------------
	logic [AW-1:0] fl_last;
	logic [WW-1:0] fl_fw;
	logic [WW-1:0] fl_lw;
	logic [4:0]    fl_lo;
	logic [4:0]    fl_hi;
	logic [31:0]   fl_mask;
	logic [31:0]   fl_wd;

	always_comb begin
		fl_last = fill_first_q + fill_n_q - AW'(1);
		fl_fw   = WW'(fill_first_q >> 5);
		fl_lw   = WW'(fl_last >> 5);
		fl_lo   = (ev_s1 == fl_fw) ? fill_first_q[4:0] : 5'd0;
		fl_hi   = (ev_s1 == fl_lw) ? fl_last[4:0] : 5'd31;
		fl_mask = (32'hFFFF_FFFF << fl_lo) & (32'hFFFF_FFFF >> (5'd31 - fl_hi));
		fl_wd   = fill_val_q ? (rdata_s1 | fl_mask) : (rdata_s1 & ~fl_mask);
	end

	// count update
	logic [AW-1:0] cnt_add;
	logic [AW-1:0] cnt_sub;

	always_comb begin
		cnt_add = (fill_n_q >= total_a - count_c) ? total_a : count_c + fill_n_q;
		cnt_sub = (fill_n_q >= count_c) ? '0 : count_c - fill_n_q;
	end

	// ---------------- map memory ----------------
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_word_q;
		mem_wd = 32'hFFFF_FFFF;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FILL && pend_s1) begin
			mem_we = 1'b1;
			mem_wa = ev_s1;
			mem_wd = fl_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) used_map[mem_wa] <= mem_wd;
		rdata_s1 <= used_map[rd_word_q];
	end

	// ---------------- ports ----------------
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tdata   = {5'd0, out_used_q, out_block_q};
	assign m_tuser   = out_status_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			map_base_q   <= MAP_BASE_RST;
			total_q      <= TOTAL_RST;
			count_q      <= TW'(FRAMES);
			kind_q       <= KIND_INIT;
			addr_q       <= '0;
			cnt_q        <= '0;
			rbytes_q     <= '0;
			init_q       <= 1'b0;
			rd_word_q    <= '0;
			ev_s1        <= '0;
			pend_s1      <= 1'b0;
			run_q        <= '0;
			runst_q      <= '0;
			fill_first_q <= '0;
			fill_n_q     <= '0;
			fill_val_q   <= 1'b0;
			status_q     <= STATUS_OK;
			block_q      <= '0;
			m_tvalid     <= 1'b0;
			out_status_q <= STATUS_OK;
			out_block_q  <= '0;
			out_used_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAP_BASE: map_base_q <= cfg_data;
					CFG_TOTAL:    total_q    <= cfg_data[FCOUNT_W-1:0];
					default:      ;
				endcase
			end

			if (m_tready) m_tvalid <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					rd_word_q <= rd_word_q + WW'(1);
					if (rd_word_q == WW'(MAP_WORDS - 1)) begin
						count_q  <= init_q ? total_eff : TW'(FRAMES);
						status_q <= STATUS_OK;
						block_q  <= '0;
						state_q  <= init_q ? ST_DONE : ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q   <= s_tuser;
						addr_q   <= s_tdata[31:0];
						cnt_q    <= s_tdata[42:32];
						rbytes_q <= s_tdata[74:43];
						state_q  <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					status_q <= STATUS_OK;
					block_q  <= '0;
					pend_s1  <= 1'b0;
					unique case (kind_q)
						KIND_INIT: begin
							init_q    <= 1'b1;
							rd_word_q <= '0;
							state_q   <= ST_CLEAR;
						end
						KIND_ALLOC: begin
							if (cnt_q == '0 || cnt_a > total_a) begin
								status_q <= STATUS_BADREQ;
								state_q  <= ST_DONE;
							end else if (total_a - count_c < cnt_a) begin
								status_q <= STATUS_NOSPACE;
								state_q  <= ST_DONE;
							end else begin
								rd_word_q <= '0;
								run_q     <= '0;
								runst_q   <= '0;
								state_q   <= ST_SCAN;
							end
						end
						KIND_FREE: begin
							if (cnt_q == '0 || free_first >= total_a || cnt_a > free_rest) begin
								status_q <= STATUS_BADREQ;
								state_q  <= ST_DONE;
							end else begin
								fill_first_q <= free_first;
								fill_n_q     <= cnt_a;
								fill_val_q   <= 1'b0;
								rd_word_q    <= WW'(free_first >> 5);
								state_q      <= ST_FILL;
							end
						end
						KIND_RELEASE, KIND_RESERVE: begin
							if (reg_n == '0 || reg_first >= total_a) begin
								status_q <= STATUS_BADREQ;
								state_q  <= ST_DONE;
							end else begin
								fill_first_q <= reg_first;
								fill_n_q     <= reg_n_clip;
								fill_val_q   <= (kind_q == KIND_RESERVE);
								rd_word_q    <= WW'(reg_first >> 5);
								state_q      <= ST_FILL;
							end
						end
						default: begin
							status_q <= STATUS_BADREQ;
							state_q  <= ST_DONE;
						end
					endcase
				end

				ST_SCAN: begin
					rd_word_q <= rd_word_q + WW'(1);
					ev_s1     <= rd_word_q;
					pend_s1   <= 1'b1;
					if (pend_s1) begin
						if (sc_found) begin
							fill_first_q <= sc_start;
							fill_n_q     <= cnt_a;
							fill_val_q   <= 1'b1;
							rd_word_q    <= WW'(sc_start >> 5);
							pend_s1      <= 1'b0;
							state_q      <= ST_FILL;
						end else if (sc_last) begin
							status_q <= STATUS_NOSPACE;
							pend_s1  <= 1'b0;
							state_q  <= ST_DONE;
						end else if (sc_fm == 32'hFFFF_FFFF) begin
							// whole word free: run carries into the next word
							run_q   <= run_q + AW'(32);
							runst_q <= (run_q == '0) ? sc_base : runst_q;
						end else begin
							run_q   <= AW'(sc_high);
							runst_q <= sc_base + AW'(32) - AW'(sc_high);
						end
					end
				end

				ST_FILL: begin
					rd_word_q <= rd_word_q + WW'(1);
					ev_s1     <= rd_word_q;
					pend_s1   <= 1'b1;
					if (pend_s1 && ev_s1 == fl_lw) begin
						pend_s1 <= 1'b0;
						state_q <= ST_COUNT;
					end
				end

				ST_COUNT: begin
					count_q <= TW'(fill_val_q ? cnt_add : cnt_sub);
					if (kind_q == KIND_ALLOC) begin
						block_q <= map_base_q + (32'(fill_first_q) << FBS);
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					init_q <= 1'b0;
					if (!m_tvalid || m_tready) begin
						m_tvalid     <= 1'b1;
						out_status_q <= status_q;
						out_block_q  <= block_q;
						out_used_q   <= used_c;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the bitmap frame allocator core.
`timescale 1ns / 1ps

module tb_top;
	import bfa_pkg::*;

	// kinds the block has no operation for
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam bit ROW_FIXED     = 1'b1;
	localparam bit ROW_PREDICTED = 1'b0;

	localparam int QUIET_LIMIT = 4000;
	localparam int REQ_USED_W  = 2 * ADDR_W + FCOUNT_W;
	localparam int RSP_USED_W  = ADDR_W + FCOUNT_W;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ADDR_W-1:0]   address;
		logic [FCOUNT_W-1:0] frame_count;
		logic [31:0]         region_bytes;
	} frame_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_address;
		logic [FCOUNT_W-1:0] used_frames;
	} frame_resp_t;

	typedef struct packed {
		bit          fixed;
		frame_req_t  rq;
		frame_resp_t rs;
	} directed_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   address;
		logic [FCOUNT_W-1:0] frames;
	} live_block_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [KIND_W-1:0]    s_tuser   = KIND_INIT;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = CFG_MAP_BASE;
	logic [31:0]          cfg_data  = '0;

	// allocator shadow state
	logic [FRAMES_DEF-1:0] frame_used   = '1;
	int unsigned           used_count   = FRAMES_DEF;
	logic [31:0]           cfg_map_base = MAP_BASE_RST;
	logic [10:0]           cfg_total    = TOTAL_RST;

	frame_resp_t pending_responses[$];
	live_block_t live_blocks[$];
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	int          stall_left   = 0;
	bit          tx_idle_on   = 1'b1;
	bit          rx_idle_on   = 1'b1;

	directed_row_t directed_rows [0:22] = '{
		'{ROW_FIXED, '{KIND_INIT, 32'h0, 11'd0, 32'h0}, '{STATUS_OK, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd1, 32'h0}, '{STATUS_NOSPACE, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd0, 32'h0}, '{STATUS_BADREQ, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd2047, 32'h0}, '{STATUS_BADREQ, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_SPARE_HI, 32'hffff_ffff, 11'h7ff, 32'hffff_ffff},
			'{STATUS_BADREQ, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_SPARE_LO, 32'h0, 11'd0, 32'h0}, '{STATUS_BADREQ, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_RELEASE, 32'h0, 11'd0, 32'h0000_0fff},
			'{STATUS_BADREQ, 32'h0, 11'd1024}},
		'{ROW_FIXED, '{KIND_RELEASE, 32'h0, 11'd0, 32'h0040_0000}, '{STATUS_OK, 32'h0, 11'd0}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd1, 32'h0}, '{STATUS_OK, 32'h0, 11'd1}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd1024, 32'h0}, '{STATUS_NOSPACE, 32'h0, 11'd1}},
		'{ROW_FIXED, '{KIND_ALLOC, 32'h0, 11'd1023, 32'h0}, '{STATUS_OK, 32'h1000, 11'd1024}},
		'{ROW_FIXED, '{KIND_FREE, 32'h1000, 11'd1023, 32'h0}, '{STATUS_OK, 32'h0, 11'd1}},
		'{ROW_FIXED, '{KIND_FREE, 32'h0, 11'd1025, 32'h0}, '{STATUS_BADREQ, 32'h0, 11'd1}},
		'{ROW_FIXED, '{KIND_FREE, 32'hffff_f000, 11'd1, 32'h0}, '{STATUS_BADREQ, 32'h0, 11'd1}},
		'{ROW_FIXED, '{KIND_RESERVE, 32'hffff_ffff, 11'd0, 32'hffff_ffff},
			'{STATUS_BADREQ, 32'h0, 11'd1}},
		// region clipped at the top frame
		'{ROW_PREDICTED, '{KIND_RESERVE, 32'h003f_f000, 11'd0, 32'hffff_ffff}, '0},
		// count drops even though these frames were already free
		'{ROW_PREDICTED, '{KIND_RELEASE, 32'h0000_2000, 11'd0, 32'h0000_2fff}, '0},
		'{ROW_PREDICTED, '{KIND_ALLOC, 32'h0, 11'd1022, 32'h0}, '0},
		'{ROW_PREDICTED, '{KIND_ALLOC, 32'h0, 11'd2, 32'h0}, '0},
		'{ROW_PREDICTED, '{KIND_FREE, 32'h0000_1000, 11'd1, 32'h0}, '0},
		'{ROW_PREDICTED, '{KIND_RELEASE, 32'h0001_e000, 11'd0, 32'h0000_4000}, '0},
		// first fit skips the lone hole and crosses a map word
		'{ROW_PREDICTED, '{KIND_ALLOC, 32'h0, 11'd4, 32'h0}, '0},
		'{ROW_FIXED, '{KIND_INIT, 32'h0, 11'd0, 32'h0}, '{STATUS_OK, 32'h0, 11'd1024}}
	};

	bitmap_frame_allocator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int unsigned eff_total();
		return (cfg_total > 11'(FRAMES_DEF)) ? FRAMES_DEF : cfg_total;
	endfunction

	function automatic void grow_count(int unsigned n, int unsigned total);
		int unsigned held;
		held = (used_count > total) ? total : used_count;
		used_count = (n >= total - held) ? total : held + n;
	endfunction

	function automatic void shrink_count(int unsigned n, int unsigned total);
		int unsigned held;
		held = (used_count > total) ? total : used_count;
		used_count = (n >= held) ? 0 : held - n;
	endfunction

	// Applies one request to the shadow map and returns the response it should produce.
	function automatic frame_resp_t apply_frame_op(frame_req_t rq);
		frame_resp_t rs;
		int unsigned total, held, first, span, run, start, f;
		logic [31:0] offset;
		bit          found;
		total = eff_total();
		held  = (used_count > total) ? total : used_count;
		rs    = '{STATUS_OK, 32'h0, 11'h0};
		case (rq.kind)
		KIND_INIT: begin
			frame_used = '1;
			used_count = total;
		end
		KIND_ALLOC: begin
			if (rq.frame_count == 0 || rq.frame_count > total) begin
				rs.status = STATUS_BADREQ;
			end else if (total - held < rq.frame_count) begin
				rs.status = STATUS_NOSPACE;
			end else begin
				run   = 0;
				start = 0;
				found = 1'b0;
				for (f = 0; f < total && !found; f++) begin
					if (frame_used[f]) begin
						run = 0;
					end else begin
						if (run == 0)
							start = f;
						run++;
						if (run == rq.frame_count)
							found = 1'b1;
					end
				end
				if (!found) begin
					rs.status = STATUS_NOSPACE;
				end else begin
					for (f = start; f < start + rq.frame_count; f++)
						frame_used[f] = 1'b1;
					grow_count(rq.frame_count, total);
					rs.block_address = cfg_map_base + start * FRAME_BYTES_DEF;
				end
			end
		end
		KIND_FREE: begin
			offset = rq.address - cfg_map_base;
			first  = offset / FRAME_BYTES_DEF;
			if (rq.frame_count == 0 || first >= total || rq.frame_count > total - first) begin
				rs.status = STATUS_BADREQ;
			end else begin
				for (f = first; f < first + rq.frame_count; f++)
					frame_used[f] = 1'b0;
				shrink_count(rq.frame_count, total);
			end
		end
		KIND_RELEASE, KIND_RESERVE: begin
			first = rq.address / FRAME_BYTES_DEF;
			span  = rq.region_bytes / FRAME_BYTES_DEF;
			if (span == 0 || first >= total) begin
				rs.status = STATUS_BADREQ;
			end else begin
				if (span > total - first)
					span = total - first;
				for (f = first; f < first + span; f++)
					frame_used[f] = (rq.kind == KIND_RESERVE);
				if (rq.kind == KIND_RESERVE)
					grow_count(span, total);
				else
					shrink_count(span, total);
			end
		end
		default: rs.status = STATUS_BADREQ;
		endcase
		rs.used_frames = (used_count > total) ? total : used_count;
		return rs;
	endfunction

	// Mostly alloc/free traffic against live blocks, with region ops, inits and noise.
	function automatic frame_req_t gen_request();
		frame_req_t  rq;
		int unsigned total, held, pick, hi, idx, span;
		total = eff_total();
		held  = (used_count > total) ? total : used_count;
		rq    = '0;
		pick  = $urandom_range(0, 99);
		if (total != 0 && held == total && pick < 65)
			pick = 66;
		if (pick < 40) begin
			rq.kind = KIND_ALLOC;
			idx = $urandom_range(0, 19);
			hi  = (total < 12) ? total : 12;
			if (hi == 0)
				hi = 1;
			if (idx == 0)
				rq.frame_count = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(total, 2047));
			else if (idx < 4)
				rq.frame_count = $urandom_range(1, (total == 0) ? 1 : total);
			else
				rq.frame_count = $urandom_range(1, hi);
		end else if (pick < 65) begin
			rq.kind = KIND_FREE;
			if (live_blocks.size() != 0 && $urandom_range(0, 9) != 0) begin
				idx = $urandom_range(0, live_blocks.size() - 1);
				rq.address     = live_blocks[idx].address;
				rq.frame_count = live_blocks[idx].frames;
				live_blocks.delete(idx);
			end else begin
				rq.address = cfg_map_base + $urandom_range(0, total) * FRAME_BYTES_DEF
					+ $urandom_range(0, FRAME_BYTES_DEF - 1);
				rq.frame_count = $urandom_range(0, 20);
			end
		end else if (pick < 87) begin
			rq.kind = (pick < 77) ? KIND_RELEASE : KIND_RESERVE;
			span = $urandom_range(1, (pick < 77) ? 48 : 16);
			rq.address = $urandom_range(0, (total == 0) ? 0 : total - 1) * FRAME_BYTES_DEF
				+ $urandom_range(0, FRAME_BYTES_DEF - 1);
			if ($urandom_range(0, 15) == 0)
				rq.region_bytes = $urandom_range(0, FRAME_BYTES_DEF - 1);
			else
				rq.region_bytes = span * FRAME_BYTES_DEF + $urandom_range(0, FRAME_BYTES_DEF - 1);
		end else if (pick < 90) begin
			rq.kind = KIND_INIT;
		end else begin
			rq.kind         = $urandom_range(0, 7);
			rq.address      = $urandom;
			rq.frame_count  = $urandom_range(0, 2047);
			rq.region_bytes = $urandom;
		end
		return rq;
	endfunction

	task automatic issue(input frame_req_t rq, input bit fixed, input frame_resp_t fixed_rs);
		frame_resp_t predicted;
		bit          taken;
		s_tvalid <= 1'b1;
		s_tuser  <= rq.kind;
		s_tdata  <= {{(S_TDATA_W - REQ_USED_W){1'b0}}, rq.region_bytes, rq.frame_count,
			rq.address};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		predicted = apply_frame_op(rq);
		pending_responses.push_back(fixed ? fixed_rs : predicted);
		if (rq.kind == KIND_INIT)
			live_blocks.delete();
		else if (rq.kind == KIND_ALLOC && predicted.status == STATUS_OK)
			live_blocks.push_back('{predicted.block_address, rq.frame_count});
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every outstanding response has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] base, input logic [31:0] total_word);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAP_BASE;
		cfg_data  <= base;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_map_base = base;
		cfg_index <= CFG_TOTAL;
		cfg_data  <= total_word;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_total = total_word[10:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [31:0] total_word,
			input int items, input bit idle);
		frame_req_t open_all;
		drain();
		set_config(base, total_word);
		tx_idle_on = idle;
		rx_idle_on = idle;
		// free the whole managed range so allocations have room
		open_all = '{KIND_RELEASE, 32'h0, 11'd0, 32'(eff_total() * FRAME_BYTES_DEF)};
		issue(open_all, ROW_PREDICTED, '0);
		for (int i = 0; i < items; i++) begin
			issue(gen_request(), ROW_PREDICTED, '0);
			if (i % 150 == 149)
				drain();
		end
	endtask

	// response stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Outputs are stable between edges, so the transaction is checked at the falling edge.
	always @(negedge clk) begin
		frame_resp_t exp_rs;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_responses.size() == 0) begin
				$error("response with no request pending: status %0d", m_tuser);
				mismatches++;
			end else begin
				exp_rs = pending_responses.pop_front();
				if (m_tuser !== exp_rs.status) begin
					$error("status: expected %0d, got %0d", exp_rs.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[ADDR_W-1:0] !== exp_rs.block_address) begin
					$error("block_address: expected %h, got %h", exp_rs.block_address,
						m_tdata[ADDR_W-1:0]);
					mismatches++;
				end
				if (m_tdata[RSP_USED_W-1:ADDR_W] !== exp_rs.used_frames) begin
					$error("used_frames: expected %0d, got %0d", exp_rs.used_frames,
						m_tdata[RSP_USED_W-1:ADDR_W]);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			issue(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].rs);

		run_phase(32'h0000_0000, 32'd1024, 300, 1'b1);
		run_phase(32'hffff_f000, 32'd40, 200, 1'b1);
		run_phase(32'hffff_ffff, 32'd1, 120, 1'b1);
		run_phase($urandom, 32'd0, 60, 1'b1);
		// upper data bits are ignored by the total register; 2047 clips to the map size
		run_phase($urandom & 32'hffff_f000, {21'($urandom), 11'd2047}, 350, 1'b0);
		run_phase(32'h8000_0000, 32'd300, 250, 1'b1);
		run_phase($urandom, 32'd1024, 350, 1'b1);
		run_phase(32'h0000_0000, 32'd64, 300, 1'b0);

		drain();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
hdl/bfa_pkg.sv
hdl/bitmap_frame_allocator_core.sv
sim/tb_top.sv
